@@ sv/hrhc_pkg.sv @@
// Package for the HTTP request head checker.
// Holds parser state codes, status codes, character constants and the step result type.
// No dependencies.
package hrhc_pkg;

   localparam int LEN_BITS = 16;

   typedef enum logic [3:0] {
      ST_WORD1 = 4'd0,
      ST_SP1   = 4'd1,
      ST_WORD2 = 4'd2,
      ST_SP2   = 4'd3,
      ST_WORD3 = 4'd4,
      ST_LF    = 4'd5,
      ST_LINE  = 4'd6,
      ST_DONE  = 4'd7,
      ST_BAD   = 4'd8
   } parse_state_type;

   localparam logic [1:0] STATUS_MORE = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_HT = 8'h09;

   typedef struct packed {
      parse_state_type next_state;
      logic            simple_hit;
   } step_type;

endpackage

@@ sv/hrhc_step.sv @@
// Byte classifier and next-state logic of the HTTP request head checker.
// Depends on hrhc_pkg.
module hrhc_step
   import hrhc_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      data_byte,
   output step_type        step
);

   logic is_letter;
   logic is_sp;
   logic is_cr;
   logic is_lf;
   logic is_ht;

   assign is_letter = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                      ((data_byte >= 8'h61) && (data_byte <= 8'h7A));
   assign is_sp = (data_byte == CH_SP);
   assign is_cr = (data_byte == CH_CR);
   assign is_lf = (data_byte == CH_LF);
   assign is_ht = (data_byte == CH_HT);

   always_comb begin
      step.simple_hit = 1'b0;
      step.next_state = ST_BAD;
      unique case (cur_state)
         ST_WORD1: begin
            if (is_sp)          step.next_state = ST_SP1;
            else if (is_letter) step.next_state = ST_WORD1;
            else                step.next_state = ST_BAD;
         end
         ST_SP1: begin
            if (is_sp)                         step.next_state = ST_SP1;
            else if (is_cr || is_lf || is_ht)  step.next_state = ST_BAD;
            else                               step.next_state = ST_WORD2;
         end
         ST_WORD2: begin
            // LF inside the target ends a simple request line
            if (is_lf) begin
               step.next_state = ST_DONE;
               step.simple_hit = 1'b1;
            end else if (is_sp) begin
               step.next_state = ST_SP2;
            end else if (is_ht) begin
               step.next_state = ST_BAD;
            end else begin
               step.next_state = ST_WORD2;
            end
         end
         ST_SP2: begin
            if (is_sp)                         step.next_state = ST_SP2;
            else if (is_cr || is_lf || is_ht)  step.next_state = ST_BAD;
            else                               step.next_state = ST_WORD3;
         end
         ST_WORD3: begin
            if (is_lf)                step.next_state = ST_LF;
            else if (is_sp || is_ht)  step.next_state = ST_BAD;
            else                      step.next_state = ST_WORD3;
         end
         ST_LF: begin
            if (is_lf)      step.next_state = ST_DONE;
            else if (is_cr) step.next_state = ST_LF;
            else            step.next_state = ST_LINE;
         end
         ST_LINE: begin
            step.next_state = is_lf ? ST_LF : ST_LINE;
         end
         default: begin
            step.next_state = ST_BAD;
         end
      endcase
   end

endmodule

@@ sv/http_request_head_checker.sv @@
// HTTP request head checker: one byte per request, one result per request. A byte sits in
// an input register, is checked against the parser state and leaves through a result
// register, so a request is taken every cycle while the result side is ready, and each
// result is held in the result register after its byte has passed the input register;
// the parser state update sets that rate. Status is need more, complete or malformed;
// complete and malformed hold until a request marked first of request restarts the check
// with a zero count. The byte count saturates at 2^COUNT_BITS-1 and is shown saturated to
// 16 bits. Depends on hrhc_pkg and hrhc_step.
module http_request_head_checker
   import hrhc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first_of_request,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_old_version,
   output logic [LEN_BITS-1:0] rsp_request_length
);

   logic                  s1_valid_ff;
   logic [7:0]            s1_byte_ff;
   logic                  s1_first_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_old_ff;
   logic [LEN_BITS-1:0]   rsp_len_ff;

   parse_state_type       state_ff;
   parse_state_type       state_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  seen_ff;
   logic                  seen_in;

   parse_state_type       cur_state;
   logic [COUNT_BITS-1:0] cur_count;
   logic                  cur_seen;
   logic                  held;
   logic                  counting;
   logic [1:0]            status_in;
   logic                  old_in;
   logic [LEN_BITS-1:0]   len_in;
   step_type              step;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // restart applies before the byte
   assign cur_state = s1_first_ff ? ST_WORD1 : state_ff;
   assign cur_count = s1_first_ff ? '0 : count_ff;
   assign cur_seen  = s1_first_ff ? 1'b0 : seen_ff;

   hrhc_step u_step (
      .cur_state (cur_state),
      .data_byte (s1_byte_ff),
      .step      (step)
   );

   always_comb begin
      held      = (cur_state == ST_DONE) || (cur_state == ST_BAD);
      state_in  = held ? cur_state : step.next_state;
      counting  = !held && (step.next_state != ST_BAD) && (cur_count != '1);
      count_in  = cur_count + COUNT_BITS'(counting);
      seen_in   = cur_seen | (!held & step.simple_hit);
      if (state_in == ST_DONE)     status_in = STATUS_DONE;
      else if (state_in == ST_BAD) status_in = STATUS_BAD;
      else                         status_in = STATUS_MORE;
      old_in = (status_in == STATUS_DONE) && seen_in;
   end

   generate
      if (COUNT_BITS > LEN_BITS) begin : g_len_sat
         assign len_in = (|count_in[COUNT_BITS-1:LEN_BITS]) ? '1 : count_in[LEN_BITS-1:0];
      end else begin : g_len_ext
         assign len_in = LEN_BITS'(count_in);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_WORD1;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            count_ff     <= count_in;
            seen_ff      <= seen_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_data_byte;
         s1_first_ff <= req_first_of_request;
      end
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_old_ff    <= old_in;
         rsp_len_ff    <= len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_old_version    = rsp_old_ff;
   assign rsp_request_length = rsp_len_ff;

   a_old_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_old_ff |-> rsp_status_ff == STATUS_DONE)
      else $error("old version flag without complete status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_MORE) || (rsp_status_ff == STATUS_DONE) ||
                       (rsp_status_ff == STATUS_BAD))
      else $error("undefined status code");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_first_ff |=> count_ff >= $past(count_ff))
      else $error("byte count decreased without restart");

   a_end_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_first_ff && (state_ff == ST_DONE || state_ff == ST_BAD)
      |=> state_ff == $past(state_ff))
      else $error("final state left without restart");

endmodule
